>>> rtl/sdiv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdiv_pkg
// Shared types and constants for the pipelined signed divider.
// ----------------------------------------------------------------------------
package sdiv_pkg;

  // Default operand width; the top level hands its parameter down.
  localparam int DATA_WIDTH_DEF = 32;

  // Width of the status field on the result channel.
  localparam int STATUS_W = 2;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

  // Control that travels alongside the datapath through every stage.
  typedef struct packed {
    logic    valid;
    logic    neg;
    status_t status;
  } meta_t;

endpackage : sdiv_pkg
`default_nettype wire

>>> rtl/sdiv_prep.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdiv_prep
// Entry stage: takes operand magnitudes, quotient sign and special cases.
// ----------------------------------------------------------------------------
module sdiv_prep #(
  parameter int DATA_WIDTH = sdiv_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [DATA_WIDTH-1:0] numerator,
  input  wire logic [DATA_WIDTH-1:0] denominator,
  output sdiv_pkg::meta_t            meta_r,
  output logic      [DATA_WIDTH-1:0] rem_r,
  output logic      [DATA_WIDTH-1:0] quo_r,
  output logic      [DATA_WIDTH-1:0] div_r
);
  import sdiv_pkg::*;

  localparam logic [DATA_WIDTH-1:0] MostNeg = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MinusOne = {DATA_WIDTH{1'b1}};

  logic                  n_neg;
  logic                  d_neg;
  meta_t                 meta_nxt;
  logic [DATA_WIDTH-1:0] quo_nxt;
  logic [DATA_WIDTH-1:0] div_nxt;

  assign n_neg   = numerator[DATA_WIDTH-1];
  assign d_neg   = denominator[DATA_WIDTH-1];
  // The most negative value maps to its own bit pattern, read as unsigned.
  assign quo_nxt = n_neg ? (~numerator + 1'b1) : numerator;
  assign div_nxt = d_neg ? (~denominator + 1'b1) : denominator;

  always_comb begin
    meta_nxt.valid = in_valid;
    meta_nxt.neg   = n_neg ^ d_neg;
    if (denominator == '0) begin
      meta_nxt.status = ST_DIV0;
    end else if (numerator == MostNeg && denominator == MinusOne) begin
      meta_nxt.status = ST_OVF;
    end else begin
      meta_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r.valid <= 1'b0;
    end else if (en) begin
      meta_r <= meta_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= '0;
      quo_r <= quo_nxt;
      div_r <= div_nxt;
    end
  end

endmodule : sdiv_prep
`default_nettype wire

>>> rtl/sdiv_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdiv_step
// One restoring division step: shifts in a dividend bit, trial-subtracts.
// ----------------------------------------------------------------------------
module sdiv_step #(
  parameter int DATA_WIDTH = sdiv_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire sdiv_pkg::meta_t       meta_i,
  input  wire logic [DATA_WIDTH-1:0] rem_i,
  input  wire logic [DATA_WIDTH-1:0] quo_i,
  input  wire logic [DATA_WIDTH-1:0] div_i,
  output sdiv_pkg::meta_t            meta_r,
  output logic      [DATA_WIDTH-1:0] rem_r,
  output logic      [DATA_WIDTH-1:0] quo_r,
  output logic      [DATA_WIDTH-1:0] div_r
);
  import sdiv_pkg::*;

  logic [DATA_WIDTH-1:0] shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  fits;
  logic [DATA_WIDTH-1:0] rem_nxt;
  logic [DATA_WIDTH-1:0] quo_nxt;

  // The partial remainder stays below a nonzero divisor, which is at most half
  // the range, so its top bit is always clear and the shift loses nothing.
  assign shifted = {rem_i[DATA_WIDTH-2:0], quo_i[DATA_WIDTH-1]};
  assign diff    = {1'b0, shifted} - {1'b0, div_i};
  assign fits    = ~diff[DATA_WIDTH];
  assign rem_nxt = fits ? diff[DATA_WIDTH-1:0] : shifted;
  assign quo_nxt = {quo_i[DATA_WIDTH-2:0], fits};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r.valid <= 1'b0;
    end else if (en) begin
      meta_r <= meta_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      div_r <= div_i;
    end
  end

endmodule : sdiv_step
`default_nettype wire

>>> rtl/sdiv_post.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdiv_post
// Output stage: applies the quotient sign and the special-case results.
// ----------------------------------------------------------------------------
module sdiv_post #(
  parameter int DATA_WIDTH = sdiv_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire sdiv_pkg::meta_t           meta_i,
  input  wire logic [DATA_WIDTH-1:0]     quo_i,
  output logic                           out_valid_r,
  output logic [DATA_WIDTH-1:0]          out_quotient_r,
  output logic [sdiv_pkg::STATUS_W-1:0]  out_status_r
);
  import sdiv_pkg::*;

  localparam logic [DATA_WIDTH-1:0] MostPos = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  logic [DATA_WIDTH-1:0] quotient_nxt;

  always_comb begin
    case (meta_i.status)
      ST_OK:   quotient_nxt = meta_i.neg ? (~quo_i + 1'b1) : quo_i;
      ST_OVF:  quotient_nxt = MostPos;
      ST_DIV0: quotient_nxt = '0;
      default: quotient_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= meta_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_quotient_r <= quotient_nxt;
      out_status_r   <= meta_i.status;
    end
  end

endmodule : sdiv_post
`default_nettype wire

>>> rtl/signed_int_divider_saturating_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_divider_saturating_top
// Pipelined signed divider, truncating toward zero, with saturation.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input beat passes the entry register, the DATA_WIDTH
// restoring-division stages and the output register to become its result beat.
// Throughput: one beat per cycle unless out_stall holds it off; one operand pair
// sits in each of the DATA_WIDTH restoring-division stages, one quotient bit each.
// Reset (synchronous, active low) clears all valid bits; data registers
// are not reset. The block holds no other state.
// ----------------------------------------------------------------------------
module signed_int_divider_saturating_top #(
  parameter int DATA_WIDTH = sdiv_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input channel.
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [DATA_WIDTH-1:0]         in_numerator,
  input  wire logic [DATA_WIDTH-1:0]         in_denominator,
  // Result channel.
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [DATA_WIDTH-1:0]              out_result_quotient,
  output logic [sdiv_pkg::STATUS_W-1:0]      out_result_status
);
  import sdiv_pkg::*;

  // The whole pipeline moves as one. It advances unless a finished result
  // sits in the output register and the receiver is holding it off. When it
  // stalls every stage keeps its contents, so nothing is lost or repeated,
  // and bubbles in front of the output still let the input side run while
  // the output register is empty.
  logic advance;

  assign advance  = ~(out_valid & out_stall);
  assign in_stall = ~advance;

  // Stage k of these arrays is the output of the k-th register stage; stage
  // zero is the entry register that holds the operand magnitudes.
  meta_t                 meta_w [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] rem_w  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] quo_w  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] div_w  [0:DATA_WIDTH];

  // Entry stage: operand magnitudes, quotient sign, and detection of the
  // zero-divisor and most-negative-by-minus-one cases.
  sdiv_prep #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (advance),
    .in_valid    (in_valid),
    .numerator   (in_numerator),
    .denominator (in_denominator),
    .meta_r      (meta_w[0]),
    .rem_r       (rem_w[0]),
    .quo_r       (quo_w[0]),
    .div_r       (div_w[0])
  );

  // One restoring step per stage, most significant quotient bit first. The
  // dividend magnitude shifts out of the quotient register as the quotient
  // bits shift in, so after the last stage it holds the unsigned quotient.
  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
    sdiv_step #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (advance),
      .meta_i (meta_w[k]),
      .rem_i  (rem_w[k]),
      .quo_i  (quo_w[k]),
      .div_i  (div_w[k]),
      .meta_r (meta_w[k+1]),
      .rem_r  (rem_w[k+1]),
      .quo_r  (quo_w[k+1]),
      .div_r  (div_w[k+1])
    );
  end

  // Output register: signed quotient, or the fixed result of a special case.
  // The final remainder and divisor are not needed past this point.
  sdiv_post #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_post (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (advance),
    .meta_i         (meta_w[DATA_WIDTH]),
    .quo_i          (quo_w[DATA_WIDTH]),
    .out_valid_r    (out_valid),
    .out_quotient_r (out_result_quotient),
    .out_status_r   (out_result_status)
  );

endmodule : signed_int_divider_saturating_top
`default_nettype wire
